>>> rtl/core/tdns_pkg.sv
// ----------------------------------------------------------------------------
// tdns_pkg
// Shared types, codes and constants of the tick driven note sequencer.
// ----------------------------------------------------------------------------
package tdns_pkg;

  localparam int unsigned PROG_DEPTH_DEF = 256;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned QDEPTH         = 2;
  localparam int unsigned NBYTES         = 5;

  localparam logic [31:0] TICK_PERIOD_RST = 32'd31250000;
  localparam logic [31:0] BLOCK_STEP_RST  = 32'd2666667;

  localparam logic [2:0] ADV_STEP = 3'd1;
  localparam logic [2:0] ADV_REST = 3'd2;
  localparam logic [2:0] ADV_NOTE = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_PERIOD = 2'd0,
    CFG_BLOCK_STEP  = 2'd1,
    CFG_RUN_ENABLE  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_BLOCK = 1'b0,
    KIND_WRITE = 1'b1
  } kind_e;

  typedef enum logic {
    EV_ON  = 1'b0,
    EV_OFF = 1'b1
  } ev_e;

  typedef enum logic [7:0] {
    OPC_NOP  = 8'd0,
    OPC_LOOP = 8'd1,
    OPC_NOTE = 8'd2,
    OPC_REST = 8'd3
  } opcode_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] prog_addr;
    logic [7:0] prog_byte;
  } in_word_t;

  typedef struct packed {
    logic       event_res;
    logic [7:0] channel;
    logic [7:0] pitch;
    logic [7:0] velocity;
    logic       last;
  } out_word_t;

endpackage

>>> rtl/core/tdns_ram.sv
// ----------------------------------------------------------------------------
// tdns_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tdns_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/core/tdns_queue.sv
// ----------------------------------------------------------------------------
// tdns_queue
// Two entry word queue between the front and the back.
// ----------------------------------------------------------------------------
module tdns_queue
  import tdns_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  in_word_t push_word_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output in_word_t pop_word_o
);

  localparam int unsigned PW = $clog2(QDEPTH);
  localparam int unsigned NW = $clog2(QDEPTH + 1);

  in_word_t        entry_q [QDEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]   count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != NW'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_word_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + NW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - NW'(1);
      end
    end
  end

endmodule

>>> rtl/core/tdns_front.sv
// ----------------------------------------------------------------------------
// tdns_front
// Configuration registers, time accumulator and word classification.
// ----------------------------------------------------------------------------
module tdns_front
  import tdns_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_word_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output in_word_t              push_word_o
);

  logic [31:0] tick_period_q, block_step_q, acc_q, acc_d;
  logic        run_enable_q;
  logic [32:0] sum;
  logic [33:0] diff;
  logic        tick, is_write, accept;

  assign sum      = {1'b0, acc_q} + {1'b0, block_step_q};
  assign diff     = {1'b0, sum} - {2'b00, tick_period_q};
  assign tick     = !diff[33] && (diff[32:0] != '0);
  assign is_write = (kind_e'(in_word_i.kind) == KIND_WRITE);

  always_comb begin
    logic [32:0] nxt;
    nxt   = tick ? diff[32:0] : sum;
    acc_d = nxt[32] ? '1 : nxt[31:0];
  end

  assign in_ready_o   = push_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = in_valid_i && (is_write || (tick && run_enable_q));
  assign push_word_o  = in_word_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_period_q <= TICK_PERIOD_RST;
      block_step_q  <= BLOCK_STEP_RST;
      run_enable_q  <= 1'b0;
      acc_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_TICK_PERIOD: tick_period_q <= cfg_data_i;
          CFG_BLOCK_STEP:  block_step_q  <= cfg_data_i;
          CFG_RUN_ENABLE:  run_enable_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (accept && !is_write) begin
        acc_q <= acc_d;
      end
    end
  end

endmodule

>>> rtl/core/tdns_back.sv
// ----------------------------------------------------------------------------
// tdns_back
// Program store access, instruction execution and event output register.
// ----------------------------------------------------------------------------
module tdns_back
  import tdns_pkg::*;
#(
  parameter int unsigned PROG_DEPTH = PROG_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  output logic      q_ready_o,
  input  in_word_t  q_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o,
  output logic      off_pend_o
);

  localparam int unsigned AW = $clog2(PROG_DEPTH);
  localparam int unsigned RW = AW + 4;
  localparam int unsigned CW = $clog2(NBYTES + 1);
  localparam int unsigned BW = $clog2(NBYTES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_EMIT
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   cnt_q;
  logic [AW-1:0]   pc_q, pc_d;
  logic            waiting_q, waiting_d;
  logic [7:0]      remaining_q, remaining_d;
  logic            on_pend_q, off_pend_q, on_d, off_d;
  logic            out_valid_q;
  out_word_t       out_q;
  logic [7:0]      byte_q [NBYTES];
  logic            ram_we, ram_re, out_free, is_write;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [7:0]      ram_rdata;

  function automatic logic [AW-1:0] pc_add(input logic [AW-1:0] pc, input logic [2:0] inc);
    logic [AW:0] s;
    s = {1'b0, pc} + (AW+1)'(inc);
    if (s >= (AW+1)'(PROG_DEPTH)) begin
      s = s - (AW+1)'(PROG_DEPTH);
    end
    return AW'(s);
  endfunction

  function automatic logic [AW-1:0] addr_wrap(input logic [7:0] a);
    logic [RW-1:0] r;
    r = RW'(a);
    for (int k = 3; k >= 0; k--) begin
      if (r >= (RW'(PROG_DEPTH) << k)) begin
        r = r - (RW'(PROG_DEPTH) << k);
      end
    end
    return AW'(r);
  endfunction

  assign is_write  = (kind_e'(q_word_i.kind) == KIND_WRITE);
  assign q_ready_o = (state_q == ST_IDLE);
  assign ram_we    = (state_q == ST_IDLE) && q_valid_i && is_write;
  assign ram_waddr = addr_wrap(q_word_i.prog_addr);
  assign ram_re    = (state_q == ST_FETCH) && (cnt_q < CW'(NBYTES));
  assign ram_raddr = pc_add(pc_q, 3'(cnt_q));
  assign out_free  = !out_valid_q || out_ready_i;

  tdns_ram #(
    .WIDTH (8),
    .DEPTH (PROG_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (q_word_i.prog_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    logic       is_note;
    logic [7:0] dur, rem0, rem1;
    is_note     = (opcode_e'(byte_q[0]) == OPC_NOTE);
    dur         = is_note ? byte_q[4] : byte_q[1];
    rem0        = waiting_q ? remaining_q : dur;
    rem1        = rem0 - 8'd1;
    pc_d        = pc_q;
    waiting_d   = waiting_q;
    remaining_d = remaining_q;
    on_d        = 1'b0;
    off_d       = 1'b0;
    unique case (opcode_e'(byte_q[0]))
      OPC_LOOP: begin
        pc_d = '0;
      end
      OPC_NOTE, OPC_REST: begin
        on_d        = is_note && !waiting_q;
        remaining_d = rem1;
        if (rem1 == 8'd0) begin
          waiting_d = 1'b0;
          off_d     = is_note;
          pc_d      = pc_add(pc_q, is_note ? ADV_NOTE : ADV_REST);
        end else begin
          waiting_d = 1'b1;
        end
      end
      default: begin
        pc_d = pc_add(pc_q, ADV_STEP);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FETCH) && (cnt_q != '0)) begin
      byte_q[BW'(cnt_q - CW'(1))] <= ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pc_q        <= '0;
      waiting_q   <= 1'b0;
      remaining_q <= '0;
      on_pend_q   <= 1'b0;
      off_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if ((state_q == ST_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i && !is_write) begin
            state_q <= ST_FETCH;
            cnt_q   <= '0;
          end
        end
        ST_FETCH: begin
          if (cnt_q == CW'(NBYTES)) begin
            state_q <= ST_EXEC;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        ST_EXEC: begin
          pc_q        <= pc_d;
          waiting_q   <= waiting_d;
          remaining_q <= remaining_d;
          on_pend_q   <= on_d;
          off_pend_q  <= off_d;
          state_q     <= (on_d || off_d) ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_q.channel   <= byte_q[1];
            out_q.pitch     <= byte_q[2];
            if (on_pend_q) begin
              out_q.event_res <= EV_ON;
              out_q.velocity  <= byte_q[3];
              out_q.last      <= !off_pend_q;
              on_pend_q       <= 1'b0;
              if (!off_pend_q) begin
                state_q <= ST_IDLE;
              end
            end else begin
              out_q.event_res <= EV_OFF;
              out_q.velocity  <= 8'd0;
              out_q.last      <= 1'b1;
              off_pend_q      <= 1'b0;
              state_q         <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign off_pend_o  = off_pend_q;

endmodule

>>> rtl/core/tick_driven_note_sequencer.sv
// ----------------------------------------------------------------------------
// tick_driven_note_sequencer
// Block-timed sequencer running a byte-coded note program on ticks.
// Write words and non-ticking block words are taken while the queue has room.
// A ticking block word holds the back while it is dequeued, while five program
// bytes are read from the single read port and while it executes, and then
// while each note event (up to 2) waits for the output register to be free.
// Reset clears control state; the program store holds garbage until written.
// ----------------------------------------------------------------------------
module tick_driven_note_sequencer
  import tdns_pkg::*;
#(
  parameter int unsigned PROG_DEPTH = PROG_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_word_o
);

  logic     push_valid, push_ready, pop_valid, pop_ready, off_pend;
  in_word_t push_word, pop_word;

  tdns_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_word_o  (push_word)
  );

  tdns_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_word_i  (push_word),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_word_o   (pop_word)
  );

  tdns_back #(
    .PROG_DEPTH (PROG_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (pop_valid),
    .q_ready_o   (pop_ready),
    .q_word_i    (pop_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .off_pend_o  (off_pend)
  );

`ifndef NO_ASSERTIONS
  a_on_not_last_has_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.event_res == EV_ON) && !out_word_o.last) |-> off_pend)
    else $error("note-on without last but no note-off pending");

  a_off_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.event_res == EV_OFF)) |->
      (out_word_o.last && (out_word_o.velocity == 8'd0)))
    else $error("note-off word malformed");

  a_off_pend_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (off_pend && !out_valid_o) |=> (off_pend || out_valid_o))
    else $error("pending note-off lost");
`endif

endmodule
